// ----- hw/rtl/snapshot_lerp_buffer_defines.svh -----
// Assertion macros used by the snapshot lerp buffer controller.
`ifndef SNAPSHOT_LERP_BUFFER_DEFINES_SVH
`define SNAPSHOT_LERP_BUFFER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SLB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("snapshot lerp buffer check failed");

// Antecedent this cycle implies consequent on the next edge.
`define SLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("snapshot lerp buffer sequence check failed");

`endif

// ----- hw/rtl/slb_pkg.sv -----
// Shared constants, types and command/status structs of the snapshot lerp buffer.
package slb_pkg;

  // Channel format and fraction precision
  localparam int CHANNEL_WIDTH = 32;
  localparam int FRACTION_BITS = 16;
  localparam int NUM_CH        = 6;
  localparam int CH_IDX_W      = $clog2(NUM_CH);

  // Port field widths
  localparam int FIELD_W   = 32;
  localparam int FUNC_W    = 2;
  localparam int DELTA_W   = 16;
  localparam int DUR_W     = 24;
  localparam int ELAPSED_W = DUR_W + 1;

  // Divider and multiplier widths
  localparam int DIV_CNT_W = $clog2(FRACTION_BITS);
  localparam int PROD_W    = CHANNEL_WIDTH + FRACTION_BITS;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRACTION_BITS - 1);

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(50000);

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;

  typedef logic signed [CHANNEL_WIDTH-1:0] ch_t;
  typedef logic [FRACTION_BITS-1:0]        frac_t;

  // Controller to datapath
  typedef struct packed {
    logic                load_target;
    logic                load_start;
    logic                tick_adv;
    logic                pass;
    logic                adopt;
    logic                div_init;
    logic                div_step;
    logic                lerp_diff;
    logic                lerp_mul;
    logic                lerp_acc;
    logic                out_load;
    logic [CH_IDX_W-1:0] ch;
  } slb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pending;
    logic due;
  } slb_status_t;

endpackage

// ----- hw/rtl/slb_ctrl.sv -----
// Sequencer of the snapshot lerp buffer: handshakes, divide and per-channel lerp steps.
`include "snapshot_lerp_buffer_defines.svh"

module slb_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [slb_pkg::FUNC_W-1:0]      func_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  slb_pkg::slb_status_t            status_i,
  output slb_pkg::slb_cmd_t               cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]                      state_q, state_d;
  logic [slb_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [slb_pkg::CH_IDX_W-1:0]    ch_q, ch_d;
  logic                            out_valid_q, out_valid_d;

  // Only the idle state takes a request
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.ch = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            slb_pkg::FUNC_TICK: begin
              if (status_i.pending) begin
                cmd_o.tick_adv = 1'b1;
                state_d        = ST_CHECK;
              end else begin
                cmd_o.pass = 1'b1;
                state_d    = ST_DONE;
              end
            end
            slb_pkg::FUNC_ADD: cmd_o.load_target = !status_i.pending;
            slb_pkg::FUNC_SET: cmd_o.load_start  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (status_i.due) begin
          cmd_o.adopt = 1'b1;
          state_d     = ST_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = slb_pkg::DIV_CNT_W'(slb_pkg::FRACTION_BITS - 1);
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          ch_d    = '0;
          state_d = ST_DIFF;
        end else begin
          cnt_d = cnt_q - slb_pkg::DIV_CNT_W'(1);
        end
      end
      ST_DIFF: begin
        cmd_o.lerp_diff = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.lerp_mul = 1'b1;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.lerp_acc = 1'b1;
        if (ch_q == slb_pkg::CH_IDX_W'(slb_pkg::NUM_CH - 1)) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + slb_pkg::CH_IDX_W'(1);
          state_d = ST_DIFF;
        end
      end
      ST_DONE: begin
        // wait for the output register to be free or emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register occupancy
  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  `SLB_ASSERT(a_load_free_slot, !cmd_o.out_load || !out_valid_q || !out_stall_i)
  `SLB_ASSERT(a_ch_in_range, ch_q <= slb_pkg::CH_IDX_W'(slb_pkg::NUM_CH - 1))
  `SLB_ASSERT_NEXT(a_div_exit, state_q == ST_DIV && cnt_q == '0, state_q == ST_DIFF && ch_q == '0)
  `SLB_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && func_i == slb_pkg::FUNC_TICK, in_stall_o)

endmodule

// ----- hw/rtl/slb_datapath.sv -----
// Datapath of the snapshot lerp buffer: state registers, divider, shared multiplier, output.
module slb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slb_pkg::DUR_W-1:0]           cfg_wdata_i,
  input  logic [slb_pkg::DELTA_W-1:0]         delta_t_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  pos_x_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  pos_y_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  heading_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  vel_x_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  vel_y_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  spin_rate_i,
  input  slb_pkg::slb_cmd_t                   cmd_i,
  output slb_pkg::slb_status_t                status_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_x_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_y_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_heading_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_vel_x_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_vel_y_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_spin_o,
  output logic                                target_reached_o
);

  localparam int CW = slb_pkg::CHANNEL_WIDTH;
  localparam int FB = slb_pkg::FRACTION_BITS;

  // State with defined reset
  logic [slb_pkg::DUR_W-1:0]     duration_q;
  slb_pkg::ch_t                  start_q [slb_pkg::NUM_CH];
  logic                          pending_q;
  logic [slb_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;

  // Payload registers
  slb_pkg::ch_t                  target_q [slb_pkg::NUM_CH];
  logic [slb_pkg::DUR_W-1:0]     rem_q;
  slb_pkg::frac_t                frac_q;
  logic [CW-1:0]                 m_q;
  logic                          neg_q;
  logic [CW-1:0]                 s_q;
  logic [slb_pkg::PROD_W-1:0]    prod_q;
  slb_pkg::ch_t                  res_q [slb_pkg::NUM_CH];
  logic                          res_reached_q;
  slb_pkg::ch_t                  out_ch_q [slb_pkg::NUM_CH];
  logic                          out_reached_q;

  slb_pkg::ch_t                  in_ch [slb_pkg::NUM_CH];
  logic [slb_pkg::ELAPSED_W:0]   elapsed_sum;
  logic [slb_pkg::ELAPSED_W-1:0] dur_ext;
  logic [slb_pkg::ELAPSED_W-1:0] rem_shl;
  logic                          rem_ge;
  slb_pkg::ch_t                  s_sel, t_sel;
  logic signed [CW:0]            diff;
  logic [CW:0]                   diff_neg;
  logic [CW-1:0]                 m_abs;
  logic [slb_pkg::PROD_W-1:0]    prod;
  logic [slb_pkg::PROD_W:0]      rnd;
  logic [CW-1:0]                 mag;
  logic [CW-1:0]                 acc;

  // Incoming channels in output order
  assign in_ch[0] = slb_pkg::ch_t'(pos_x_i);
  assign in_ch[1] = slb_pkg::ch_t'(pos_y_i);
  assign in_ch[2] = slb_pkg::ch_t'(heading_i);
  assign in_ch[3] = slb_pkg::ch_t'(vel_x_i);
  assign in_ch[4] = slb_pkg::ch_t'(vel_y_i);
  assign in_ch[5] = slb_pkg::ch_t'(spin_rate_i);

  // Saturating time advance and arrival test
  assign elapsed_sum = {1'b0, elapsed_q} + (slb_pkg::ELAPSED_W + 1)'(delta_t_i);
  assign elapsed_d   = elapsed_sum[slb_pkg::ELAPSED_W] ? '1
                                                      : elapsed_sum[slb_pkg::ELAPSED_W-1:0];
  assign dur_ext      = {1'b0, duration_q};
  assign status_o.due     = (elapsed_q >= dur_ext);
  assign status_o.pending = pending_q;

  // Restoring divide step, one fraction bit per cycle
  assign rem_shl = {rem_q, 1'b0};
  assign rem_ge  = (rem_shl >= dur_ext);

  // Channel difference and magnitude
  assign s_sel    = start_q[cmd_i.ch];
  assign t_sel    = target_q[cmd_i.ch];
  assign diff     = (CW + 1)'(t_sel) - (CW + 1)'(s_sel);
  assign diff_neg = -diff;
  assign m_abs    = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

  // Shared multiplier
  assign prod = slb_pkg::PROD_W'(m_q) * slb_pkg::PROD_W'(frac_q);

  // Round half up on the magnitude, then step from start toward target
  assign rnd = {1'b0, prod_q} + slb_pkg::ROUND_HALF;
  assign mag = rnd[FB +: CW];
  assign acc = neg_q ? (s_q - mag) : (s_q + mag);

  // Configuration and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= slb_pkg::DUR_RESET;
      pending_q  <= 1'b0;
      elapsed_q  <= '0;
      for (int i = 0; i < slb_pkg::NUM_CH; i++) begin
        start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        duration_q <= cfg_wdata_i;
      end
      if (cmd_i.load_target) begin
        pending_q <= 1'b1;
      end else if (cmd_i.adopt) begin
        pending_q <= 1'b0;
      end
      if (cmd_i.load_start || cmd_i.adopt) begin
        elapsed_q <= '0;
      end else if (cmd_i.tick_adv) begin
        elapsed_q <= elapsed_d;
      end
      for (int i = 0; i < slb_pkg::NUM_CH; i++) begin
        if (cmd_i.load_start) begin
          start_q[i] <= in_ch[i];
        end else if (cmd_i.adopt) begin
          start_q[i] <= target_q[i];
        end
      end
    end
  end

  // Target, divider, lerp pipeline and output register
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < slb_pkg::NUM_CH; i++) begin
      if (cmd_i.load_target) begin
        target_q[i] <= in_ch[i];
      end
      if (cmd_i.pass) begin
        res_q[i] <= start_q[i];
      end else if (cmd_i.adopt) begin
        res_q[i] <= target_q[i];
      end
      if (cmd_i.out_load) begin
        out_ch_q[i] <= res_q[i];
      end
    end
    if (cmd_i.pass || cmd_i.div_init) begin
      res_reached_q <= 1'b0;
    end else if (cmd_i.adopt) begin
      res_reached_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_reached_q <= res_reached_q;
    end
    // remainder stays below the duration, so it fits the duration width
    if (cmd_i.div_init) begin
      rem_q  <= elapsed_q[slb_pkg::DUR_W-1:0];
      frac_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? slb_pkg::DUR_W'(rem_shl - dur_ext) : rem_shl[slb_pkg::DUR_W-1:0];
      frac_q <= {frac_q[FB-2:0], rem_ge};
    end
    if (cmd_i.lerp_diff) begin
      m_q   <= m_abs;
      neg_q <= diff[CW];
      s_q   <= s_sel;
    end
    if (cmd_i.lerp_mul) begin
      prod_q <= prod;
    end
    if (cmd_i.lerp_acc) begin
      res_q[cmd_i.ch] <= slb_pkg::ch_t'(acc);
    end
  end

  // Result fields
  assign out_x_o          = slb_pkg::FIELD_W'(out_ch_q[0]);
  assign out_y_o          = slb_pkg::FIELD_W'(out_ch_q[1]);
  assign out_heading_o    = slb_pkg::FIELD_W'(out_ch_q[2]);
  assign out_vel_x_o      = slb_pkg::FIELD_W'(out_ch_q[3]);
  assign out_vel_y_o      = slb_pkg::FIELD_W'(out_ch_q[4]);
  assign out_spin_o       = slb_pkg::FIELD_W'(out_ch_q[5]);
  assign target_reached_o = out_reached_q;

endmodule

// ----- hw/rtl/snapshot_lerp_buffer.sv -----
// Top level of the snapshot lerp buffer: controller and datapath.
//
// Six-channel Q16.16 linear interpolation between a start snapshot and one
// pending target. Add and set requests give no result; an add is ignored
// while a target is pending. A tick gives one result: with no target pending
// the start snapshot goes to the output register, when the target is reached
// the target is adopted as the new start and sent out, and otherwise the
// fraction elapsed/duration comes from a restoring divider producing one bit
// per cycle, then a single shared 32x16 multiplier visits the channels in turn,
// three steps per channel (difference, multiply, round and add). Results sit in
// an output register, so the next request is taken while a result waits.
module snapshot_lerp_buffer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slb_pkg::DUR_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [slb_pkg::FUNC_W-1:0]          func_i,
  input  logic [slb_pkg::DELTA_W-1:0]         delta_t_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  pos_x_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  pos_y_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  heading_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  vel_x_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  vel_y_i,
  input  logic signed [slb_pkg::FIELD_W-1:0]  spin_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_x_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_y_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_heading_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_vel_x_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_vel_y_o,
  output logic signed [slb_pkg::FIELD_W-1:0]  out_spin_o,
  output logic                                target_reached_o
);

  slb_pkg::slb_cmd_t    cmd;
  slb_pkg::slb_status_t status;

  // Sequencer
  slb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  slb_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .delta_t_i        (delta_t_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .heading_i        (heading_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .spin_rate_i      (spin_rate_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_heading_o    (out_heading_o),
    .out_vel_x_o      (out_vel_x_o),
    .out_vel_y_o      (out_vel_y_o),
    .out_spin_o       (out_spin_o),
    .target_reached_o (target_reached_o)
  );

endmodule
